FILE: sv/ffd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffd_pkg
// shared types, constants and helper functions of the form field extractor
// ----------------------------------------------------------------------------
package ffd_pkg;

  localparam int NAME_BYTES_DEF = 8;
  localparam int OUT_MAX_DEF    = 256;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // flag candidates "1", "true", "on", first char at index 0
  localparam logic [7:0]       CAND_ONE  = 8'h31;
  localparam logic [3:0][7:0]  CAND_TRUE = {8'h65, 8'h75, 8'h72, 8'h74};
  localparam logic [1:0][7:0]  CAND_ON   = {8'h6E, 8'h6F};
  localparam logic [7:0]       LEN_ONE   = 8'd1;
  localparam logic [7:0]       LEN_TRUE  = 8'd4;
  localparam logic [7:0]       LEN_ON    = 8'd2;

  typedef enum logic [1:0] {
    PH_MATCH,
    PH_SKIP,
    PH_VALUE,
    PH_AFTER
  } phase_t;

  typedef enum logic [1:0] {
    ESC_NONE,
    ESC_PCT,
    ESC_HEX
  } esc_t;

  typedef enum logic [1:0] {
    CFG_FIELD_NAME,
    CFG_NAME_LENGTH,
    CFG_OUT_CAPACITY
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] body_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] value_byte;
    logic       byte_valid;
    logic       done_res;
    logic       found;
    logic       flag_true;
    logic [7:0] value_length;
  } out_item_t;

  // work for the back end: decoded bytes in order, then an optional end-of-body report
  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][7:0] bytes;
    logic            term;
    logic            found;
  } entry_t;

  function automatic logic hex_ok(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if (c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h61) begin
      v = c - 8'h57;
    end else begin
      v = c - 8'h37;
    end
    return v[3:0];
  endfunction

  function automatic logic [2:0] flag_mask_step(input logic [2:0] mask,
                                                input logic [2:0] pos,
                                                input logic [7:0] b);
    logic [2:0] m;
    m = mask;
    if (!(pos == 3'd0 && b == CAND_ONE)) m[0] = 1'b0;
    if (!(pos < 3'd4 && b == CAND_TRUE[pos[1:0]])) m[1] = 1'b0;
    if (!(pos < 3'd2 && b == CAND_ON[pos[0]])) m[2] = 1'b0;
    return m;
  endfunction

endpackage

FILE: sv/ffd_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffd_stream_if
// valid/ready channel carrying one item of a given payload type
// ----------------------------------------------------------------------------
interface ffd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: sv/form_field_extract_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// form_field_extract_decode
// extracts and percent-decodes one named field from a url-encoded form body
// ----------------------------------------------------------------------------
// usage:
//   in_if  carries one body byte per item; a zero byte ends the body
//   out_if carries decoded value bytes (byte_valid set) and, for each zero
//          byte, one final report item with done_res, found, flag_true and
//          value_length
//   cfg_we/cfg_index/cfg_wdata write field_name, name_length, out_capacity;
//          write only while no item is in flight
// path: an accepted byte goes through the queue, then the result register
// throughput: one body byte per cycle while the queue has room; the output
//   sequencer takes decoded byte candidates and end reports one at a time,
//   so a byte that breaks an escape or ends the body with an escape open
//   yields up to three of them; a four-entry queue lets the parser run ahead meanwhile
// reset: synchronous on rst_n low; parse state and the queue are cleared,
//   registers return to name 0, length 1, capacity 64
// stall: a held out_if.ready keeps the result register; the parser keeps
//   accepting until the queue fills, then drops in_if.ready
// ----------------------------------------------------------------------------
module form_field_extract_decode
  import ffd_pkg::*;
#(
  parameter int NAME_BYTES = NAME_BYTES_DEF,
  parameter int OUT_MAX    = OUT_MAX_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [63:0]  cfg_wdata,
  ffd_stream_if.sink   in_if,
  ffd_stream_if.source out_if
);

  logic [NAME_BYTES-1:0][7:0] field_name_r;
  logic [3:0]                 name_length_r;
  logic [8:0]                 out_capacity_r;

  logic   q_push, q_pop, q_empty, q_full;
  entry_t q_in, q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_name_r   <= '0;
      name_length_r  <= 4'd1;
      out_capacity_r <= 9'd64;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FIELD_NAME:   field_name_r   <= cfg_wdata[NAME_BYTES*8-1:0];
        CFG_NAME_LENGTH:  name_length_r  <= cfg_wdata[3:0];
        CFG_OUT_CAPACITY: out_capacity_r <= cfg_wdata[8:0];
        default: begin
        end
      endcase
    end
  end

  ffd_front #(
    .NAME_BYTES(NAME_BYTES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .field_name (field_name_r),
    .name_length(name_length_r),
    .in_if      (in_if),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_in)
  );

  ffd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_in),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  ffd_back #(
    .OUT_MAX(OUT_MAX)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_capacity(out_capacity_r),
    .head        (q_head),
    .empty       (q_empty),
    .pop         (q_pop),
    .out_if      (out_if)
  );

endmodule

FILE: sv/ffd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffd_front
// field parser: name match, field skipping and escape tracking; while the queue has room, one byte a cycle
// ----------------------------------------------------------------------------
module ffd_front
  import ffd_pkg::*;
#(
  parameter int NAME_BYTES = NAME_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [NAME_BYTES-1:0][7:0] field_name,
  input  logic [3:0]                 name_length,
  ffd_stream_if.sink                 in_if,
  input  logic                       q_full,
  output logic                       q_push,
  output entry_t                     q_data
);

  localparam int NB_IW = (NAME_BYTES > 1) ? $clog2(NAME_BYTES) : 1;
  localparam logic [3:0] NAME_MAX = 4'(NAME_BYTES);

  phase_t     phase_r, phase_nxt;
  esc_t       esc_r, esc_nxt;
  logic [3:0] pos_r, pos_nxt;
  logic [7:0] pend_r, pend_nxt;
  logic       found_r, found_nxt;

  logic       accept;
  logic [7:0] b;
  logic       term;
  logic [3:0] nlen;
  logic [7:0] name_b;
  entry_t     ent;

  assign in_if.ready = !q_full;
  assign accept      = in_if.valid && !q_full;
  assign b           = in_if.data.body_byte;
  assign term        = (b == 8'h00);
  assign nlen        = (name_length > NAME_MAX) ? NAME_MAX : name_length;
  assign name_b      = field_name[pos_r[NB_IW-1:0]];

  function automatic entry_t push(input entry_t e, input logic [7:0] x);
    entry_t r;
    r = e;
    r.bytes[r.cnt] = x;
    r.cnt = r.cnt + 2'd1;
    return r;
  endfunction

  function automatic entry_t push_plain(input entry_t e, input logic [7:0] x);
    entry_t r;
    r = e;
    if (x == CH_PLUS) begin
      r = push(r, CH_SPACE);
    end else if (x != CH_AMP && x != CH_PCT) begin
      r = push(r, x);
    end
    return r;
  endfunction

  // next state
  always_comb begin
    phase_nxt = phase_r;
    esc_nxt   = esc_r;
    pos_nxt   = pos_r;
    pend_nxt  = pend_r;
    found_nxt = found_r;
    if (accept) begin
      if (term) begin
        phase_nxt = PH_MATCH;
        esc_nxt   = ESC_NONE;
        pos_nxt   = 4'd0;
        pend_nxt  = 8'h00;
        found_nxt = 1'b0;
      end else begin
        unique case (phase_r)
          PH_MATCH: begin
            if (b == CH_AMP) begin
              pos_nxt = 4'd0;
            end else if (pos_r < nlen) begin
              if (name_b == b) pos_nxt = pos_r + 4'd1;
              else phase_nxt = PH_SKIP;
            end else if (b == CH_EQ) begin
              phase_nxt = PH_VALUE;
              found_nxt = 1'b1;
            end else begin
              phase_nxt = PH_SKIP;
            end
          end
          PH_SKIP: begin
            if (b == CH_AMP) begin
              phase_nxt = PH_MATCH;
              pos_nxt   = 4'd0;
            end
          end
          PH_VALUE: begin
            if (esc_r == ESC_PCT && hex_ok(b)) begin
              pend_nxt = b;
              esc_nxt  = ESC_HEX;
            end else if (esc_r == ESC_HEX && hex_ok(b)) begin
              esc_nxt = ESC_NONE;
            end else begin
              esc_nxt = ESC_NONE;
              if (b == CH_AMP) phase_nxt = PH_AFTER;
              else if (b == CH_PCT) esc_nxt = ESC_PCT;
            end
          end
          PH_AFTER: begin
          end
          default: begin
          end
        endcase
      end
    end
  end

  // bytes handed to the back end
  always_comb begin
    ent       = '0;
    ent.term  = term;
    ent.found = found_r;
    if (term) begin
      if (phase_r == PH_VALUE) begin
        if (esc_r != ESC_NONE) ent = push(ent, CH_PCT);
        if (esc_r == ESC_HEX) ent = push(ent, pend_r);
      end
    end else if (phase_r == PH_VALUE) begin
      unique case (esc_r)
        ESC_NONE: ent = push_plain(ent, b);
        ESC_PCT: begin
          if (!hex_ok(b)) begin
            ent = push(ent, CH_PCT);
            ent = push_plain(ent, b);
          end
        end
        ESC_HEX: begin
          if (hex_ok(b)) begin
            ent = push(ent, {hex_val(pend_r), hex_val(b)});
          end else begin
            ent = push(ent, CH_PCT);
            ent = push(ent, pend_r);
            ent = push_plain(ent, b);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign q_data = ent;
  assign q_push = accept && (ent.term || ent.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_MATCH;
      esc_r   <= ESC_NONE;
      pos_r   <= 4'd0;
      pend_r  <= 8'h00;
      found_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      esc_r   <= esc_nxt;
      pos_r   <= pos_nxt;
      pend_r  <= pend_nxt;
      found_r <= found_nxt;
    end
  end

endmodule

FILE: sv/ffd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffd_queue
// short fifo of parsed work between the parser and the output sequencer
// ----------------------------------------------------------------------------
module ffd_queue
  import ffd_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_data,
  input  logic   pop,
  output entry_t head,
  output logic   empty,
  output logic   full
);

  entry_t          mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == (Q_AW+1)'(Q_DEPTH));
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + Q_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + Q_AW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) count_nxt = count_r + (Q_AW+1)'(1);
    else if (do_pop && !do_push) count_nxt = count_r - (Q_AW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: sv/ffd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffd_back
// output sequencer: capacity and zero cut-off, flag match, result register
// ----------------------------------------------------------------------------
module ffd_back
  import ffd_pkg::*;
#(
  parameter int OUT_MAX = OUT_MAX_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic [8:0]   out_capacity,
  input  entry_t       head,
  input  logic         empty,
  output logic         pop,
  ffd_stream_if.source out_if
);

  localparam int CAP_LIM = (OUT_MAX < 256) ? OUT_MAX : 256;
  localparam logic [8:0] CAP_MAX = 9'(CAP_LIM);

  logic [1:0] idx_r, idx_nxt;
  logic [7:0] emitted_r, emitted_nxt;
  logic       zero_r, zero_nxt;
  logic [2:0] mask_r, mask_nxt;
  logic [2:0] pos_r, pos_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_r, out_nxt;

  logic [8:0] cap;
  logic [8:0] cap_m1;
  logic [7:0] limit;
  logic       adv, term_slot, last, can_put, byte_emit;
  logic [7:0] cur;
  logic       flag;

  assign cap    = (out_capacity > CAP_MAX) ? CAP_MAX : out_capacity;
  assign cap_m1 = cap - 9'd1;
  assign limit  = (cap == 9'd0) ? 8'd0 : cap_m1[7:0];

  assign adv       = !empty && (!out_valid_r || out_if.ready);
  assign term_slot = (idx_r == head.cnt);
  assign last      = term_slot || (!head.term && idx_r == head.cnt - 2'd1);
  assign cur       = head.bytes[idx_r];
  assign can_put   = !zero_r && (emitted_r < limit);
  assign byte_emit = adv && !term_slot && can_put && (cur != 8'h00);
  assign pop       = adv && last;

  assign flag = head.found && ((mask_r[0] && emitted_r == LEN_ONE) ||
                               (mask_r[1] && emitted_r == LEN_TRUE) ||
                               (mask_r[2] && emitted_r == LEN_ON));

  always_comb begin
    idx_nxt       = idx_r;
    emitted_nxt   = emitted_r;
    zero_nxt      = zero_r;
    mask_nxt      = mask_r;
    pos_nxt       = pos_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    if (adv) begin
      idx_nxt = last ? 2'd0 : idx_r + 2'd1;
      if (term_slot) begin
        out_valid_nxt        = 1'b1;
        out_nxt.value_byte   = 8'h00;
        out_nxt.byte_valid   = 1'b0;
        out_nxt.done_res     = 1'b1;
        out_nxt.found        = head.found;
        out_nxt.flag_true    = flag;
        out_nxt.value_length = head.found ? emitted_r : 8'd0;
        emitted_nxt          = 8'd0;
        zero_nxt             = 1'b0;
        mask_nxt             = 3'b111;
        pos_nxt              = 3'd0;
      end else if (can_put) begin
        if (cur == 8'h00) begin
          zero_nxt = 1'b1;
        end else begin
          out_valid_nxt        = 1'b1;
          out_nxt.value_byte   = cur;
          out_nxt.byte_valid   = 1'b1;
          out_nxt.done_res     = 1'b0;
          out_nxt.found        = 1'b0;
          out_nxt.flag_true    = 1'b0;
          out_nxt.value_length = 8'd0;
          mask_nxt             = flag_mask_step(mask_r, pos_r, cur);
          pos_nxt              = (pos_r == 3'd7) ? pos_r : pos_r + 3'd1;
          emitted_nxt          = emitted_r + 8'd1;
        end
      end
    end
  end

  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_r;

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 2'd0;
      emitted_r   <= 8'd0;
      zero_r      <= 1'b0;
      mask_r      <= 3'b111;
      pos_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      emitted_r   <= emitted_nxt;
      zero_r      <= zero_nxt;
      mask_r      <= mask_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTH
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    byte_emit |=> emitted_r == $past(emitted_r) + 8'd1)
    else $error("emitted count did not advance with a byte item");

  a_report_clears: assert property (@(posedge clk) disable iff (!rst_n)
    adv && term_slot |=> emitted_r == 8'd0 && mask_r == 3'b111 && !zero_r)
    else $error("value state not cleared after end of body");

  a_report_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.done_res |-> !out_r.byte_valid &&
      (out_r.found || (out_r.value_length == 8'd0 && !out_r.flag_true)))
    else $error("end of body report inconsistent");
`endif

endmodule
